### hdl/arfs_pkg.sv
package arfs_pkg;

    // Fixed field widths of the item and of the count register.
    localparam int ADDR_W  = 64;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    // Item kinds.
    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } arfs_kind_t;

    // One range entry as it is stored in the table.
    typedef struct packed
    {
        logic [ADDR_W-1:0] range_begin;
        logic [ADDR_W-1:0] range_end;
    } arfs_entry_t;

endpackage

### hdl/arfs_table.sv
module arfs_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  arfs_pkg::arfs_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output arfs_pkg::arfs_entry_t rd_data
);
    import arfs_pkg::*;

    arfs_entry_t mem [DEPTH];
    arfs_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/address_range_filter_search.sv
// Address range filter. A write item (kind 0) stores one range entry and
// gives no result. A query item (kind 1) runs a binary search over entries
// 0 to min(filter_count, TABLE_DEPTH)-1, one table read per cycle, and
// raises done for one cycle, with address_valid, once the last probe has
// been compared. start is taken only while busy is low; a query with a
// count of zero always passes. The range table has a single read port,
// which serves one probe a cycle.
// busy is high while a search runs; done cannot be held off, so the user
// must take the result in the cycle it is shown. Write filter_count only
// while busy is low.
module address_range_filter_search #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [arfs_pkg::INDEX_W-1:0]  entry_index,
    input  logic [arfs_pkg::ADDR_W-1:0]   entry_begin,
    input  logic [arfs_pkg::ADDR_W-1:0]   entry_end,
    input  logic [arfs_pkg::ADDR_W-1:0]   query_address,
    input  logic                          filter_count_wr_en,
    input  logic [arfs_pkg::COUNT_W-1:0]  filter_count_wr_data,
    output logic                          done,
    output logic                          address_valid
);
    import arfs_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic
    {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t            state_reg;
    logic [COUNT_W-1:0] filter_count_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  hix_reg;
    logic [CNT_W-1:0]  lo_next;
    logic [CNT_W-1:0]  hix_next;
    logic [IDX_W-1:0]  probe_reg;
    logic [IDX_W-1:0]  probe_next;
    logic [ADDR_W-1:0] addr_reg;
    logic              done_reg;
    logic              valid_reg;

    logic              accept;
    logic              query_start;
    logic              wr_en;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W:0]    mid_sum;
    logic              hit;
    logic              stop_miss;
    logic              finish;
    logic              rd_en;
    arfs_entry_t       wr_data;
    arfs_entry_t       rd_data;

    assign accept      = start && (state_reg == S_IDLE);
    assign query_start = accept && (kind == KIND_QUERY);
    assign wr_en       = accept && (kind == KIND_WRITE)
                         && (int'(entry_index) < TABLE_DEPTH);

    assign wr_data.range_begin = entry_begin;
    assign wr_data.range_end   = entry_end;

    // Count register saturated to the table depth.
    always_comb
    begin
        if (int'(filter_count_reg) > TABLE_DEPTH)
        begin
            limit = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            limit = CNT_W'(filter_count_reg);
        end
    end

    // Compare the probed entry and narrow the search window. The window is
    // kept as lo (inclusive) and hix (exclusive); it is empty when lo >= hix.
    always_comb
    begin
        hit       = (addr_reg >= rd_data.range_begin) && (addr_reg < rd_data.range_end);
        stop_miss = 1'b0;
        lo_next   = lo_reg;
        hix_next  = hix_reg;
        if (state_reg == S_IDLE)
        begin
            lo_next  = '0;
            hix_next = limit;
        end
        else if (!hit)
        begin
            if (addr_reg < rd_data.range_begin)
            begin
                hix_next = CNT_W'(probe_reg);
            end
            else if (addr_reg > rd_data.range_begin)
            begin
                lo_next = CNT_W'(probe_reg) + CNT_W'(1);
            end
            else
            begin
                // Address sits on the begin of an empty range.
                stop_miss = 1'b1;
            end
        end
        finish     = hit || stop_miss || (lo_next >= hix_next);
        mid_sum    = {1'b0, lo_next} + {1'b0, hix_next} - (CNT_W+1)'(1);
        probe_next = mid_sum[IDX_W:1];
    end

    // Read the next probe: the first one at acceptance, later ones while
    // the search goes on.
    assign rd_en = (query_start && (limit != '0))
                   || ((state_reg == S_PROBE) && !finish);

    arfs_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(entry_index)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (probe_next),
        .rd_data (rd_data)
    );

    // Search sequencer with registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            filter_count_reg <= '0;
            done_reg         <= 1'b0;
            valid_reg        <= 1'b0;
            lo_reg           <= '0;
            hix_reg          <= '0;
            probe_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (filter_count_wr_en)
            begin
                filter_count_reg <= filter_count_wr_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (query_start)
                    begin
                        if (limit == '0)
                        begin
                            done_reg  <= 1'b1;
                            valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_PROBE;
                            lo_reg    <= lo_next;
                            hix_reg   <= hix_next;
                            probe_reg <= probe_next;
                        end
                    end
                end
                S_PROBE:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        valid_reg <= hit;
                    end
                    else
                    begin
                        lo_reg    <= lo_next;
                        hix_reg   <= hix_next;
                        probe_reg <= probe_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Query address held for the whole search.
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            addr_reg <= query_address;
        end
    end

    assign busy          = (state_reg == S_PROBE);
    assign done          = done_reg;
    assign address_valid = valid_reg;

    // The search window is never empty while probing.
    a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg < hix_reg))
        else $error("search window empty while probing");

    // The probed entry lies inside the window and inside the count.
    a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> ((CNT_W'(probe_reg) >= lo_reg)
            && (CNT_W'(probe_reg) < hix_reg) && (hix_reg <= limit)))
        else $error("probe outside search window");

    // A result is shown only once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while searching");

    // A query with a filter count of zero passes in the next cycle.
    a_empty_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (query_start && (limit == '0)) |=> (done_reg && valid_reg))
        else $error("empty table query did not pass");

endmodule
